[src/ipv4dbf_pkg.sv]
package ipv4dbf_pkg;

   localparam int unsigned ByteWidth      = 8;
   localparam int unsigned CountWidth     = 7;
   localparam int unsigned EtherTypeWidth = 16;
   localparam int unsigned IhlWidth       = 4;
   localparam int unsigned AddrWidth      = 32;
   localparam int unsigned ReasonWidth    = 3;
   localparam int unsigned RspDataWidth   = 8;

   localparam logic [CountWidth-1:0]     CountMax       = 7'd127;
   localparam logic [CountWidth-1:0]     EthHeaderBytes = 7'd14;
   localparam logic [CountWidth-1:0]     Ipv4MinEnd     = 7'd34;
   localparam logic [CountWidth-1:0]     PosTypeHigh    = 7'd12;
   localparam logic [CountWidth-1:0]     PosTypeLow     = 7'd13;
   localparam logic [CountWidth-1:0]     PosIhl         = 7'd14;
   localparam logic [CountWidth-1:0]     PosDestFirst   = 7'd30;
   localparam logic [CountWidth-1:0]     PosDestLast    = 7'd33;
   localparam logic [EtherTypeWidth-1:0] Ipv4EtherType  = 16'h0800;
   localparam logic [IhlWidth-1:0]       MinHeaderWords = 4'd5;

   typedef enum logic [ReasonWidth-1:0] {
      REASON_DROP_MATCH = 3'd0,
      REASON_SHORT_ETH  = 3'd1,
      REASON_NOT_IPV4   = 3'd2,
      REASON_SHORT_IP   = 3'd3,
      REASON_BAD_IHL    = 3'd4,
      REASON_IHL_BEYOND = 3'd5,
      REASON_OTHER_DEST = 3'd6
   } reason_type;

   typedef struct packed {
      logic                      last;
      logic [CountWidth-1:0]     length;
      logic [EtherTypeWidth-1:0] ether_type;
      logic [IhlWidth-1:0]       header_words;
      logic [AddrWidth-1:0]      dest_address;
   } frame_sum_type;

   typedef struct packed {
      logic       drop_frame;
      reason_type verdict_reason;
   } verdict_type;

endpackage

[src/ipv4dbf_parse.sv]
module ipv4dbf_parse (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   beat_accept,
   input  logic [ipv4dbf_pkg::ByteWidth-1:0]      frame_byte,
   input  logic                                   last_byte,
   output ipv4dbf_pkg::frame_sum_type             frame_sum
);

   logic [ipv4dbf_pkg::CountWidth-1:0]     byte_count_ff, byte_count_in, count_sat;
   logic [ipv4dbf_pkg::EtherTypeWidth-1:0] ether_type_ff, ether_type_in, ether_type_cap;
   logic [ipv4dbf_pkg::IhlWidth-1:0]       header_words_ff, header_words_in, header_words_cap;
   logic [ipv4dbf_pkg::AddrWidth-1:0]      dest_address_ff, dest_address_in, dest_address_cap;

   always_comb begin
      ether_type_cap   = ether_type_ff;
      header_words_cap = header_words_ff;
      dest_address_cap = dest_address_ff;
      if (byte_count_ff == ipv4dbf_pkg::PosTypeHigh) begin
         ether_type_cap = {frame_byte, ether_type_ff[7:0]};
      end else if (byte_count_ff == ipv4dbf_pkg::PosTypeLow) begin
         ether_type_cap = {ether_type_ff[15:8], frame_byte};
      end else if (byte_count_ff == ipv4dbf_pkg::PosIhl) begin
         header_words_cap = frame_byte[ipv4dbf_pkg::IhlWidth-1:0];
      end else if (byte_count_ff >= ipv4dbf_pkg::PosDestFirst &&
                   byte_count_ff <= ipv4dbf_pkg::PosDestLast) begin
         dest_address_cap = {dest_address_ff[23:0], frame_byte};
      end
      count_sat = (byte_count_ff < ipv4dbf_pkg::CountMax) ?
                  byte_count_ff + 7'd1 : byte_count_ff;
   end

   always_comb begin
      byte_count_in   = byte_count_ff;
      ether_type_in   = ether_type_ff;
      header_words_in = header_words_ff;
      dest_address_in = dest_address_ff;
      if (beat_accept) begin
         if (last_byte) begin
            byte_count_in   = '0;
            ether_type_in   = '0;
            header_words_in = '0;
            dest_address_in = '0;
         end else begin
            byte_count_in   = count_sat;
            ether_type_in   = ether_type_cap;
            header_words_in = header_words_cap;
            dest_address_in = dest_address_cap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         ether_type_ff   <= '0;
         header_words_ff <= '0;
         dest_address_ff <= '0;
      end else begin
         byte_count_ff   <= byte_count_in;
         ether_type_ff   <= ether_type_in;
         header_words_ff <= header_words_in;
         dest_address_ff <= dest_address_in;
      end
   end

   assign frame_sum.last         = beat_accept & last_byte;
   assign frame_sum.length       = count_sat;
   assign frame_sum.ether_type   = ether_type_cap;
   assign frame_sum.header_words = header_words_cap;
   assign frame_sum.dest_address = dest_address_cap;

endmodule

[src/ipv4dbf_judge.sv]
module ipv4dbf_judge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [ipv4dbf_pkg::AddrWidth-1:0]     csr_wr_data,
   input  ipv4dbf_pkg::frame_sum_type            frame_sum,
   output ipv4dbf_pkg::verdict_type              verdict
);

   logic [ipv4dbf_pkg::AddrWidth-1:0]  blocked_address_ff, blocked_address_in;
   logic [ipv4dbf_pkg::CountWidth-1:0] header_end;

   assign blocked_address_in = csr_wr_en ? csr_wr_data : blocked_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_address_ff <= '0;
      end else begin
         blocked_address_ff <= blocked_address_in;
      end
   end

   assign header_end = ipv4dbf_pkg::EthHeaderBytes + {1'b0, frame_sum.header_words, 2'b00};

   always_comb begin
      if (frame_sum.length < ipv4dbf_pkg::EthHeaderBytes) begin
         verdict.verdict_reason = ipv4dbf_pkg::REASON_SHORT_ETH;
      end else if (frame_sum.ether_type != ipv4dbf_pkg::Ipv4EtherType) begin
         verdict.verdict_reason = ipv4dbf_pkg::REASON_NOT_IPV4;
      end else if (frame_sum.length < ipv4dbf_pkg::Ipv4MinEnd) begin
         verdict.verdict_reason = ipv4dbf_pkg::REASON_SHORT_IP;
      end else if (frame_sum.header_words < ipv4dbf_pkg::MinHeaderWords) begin
         verdict.verdict_reason = ipv4dbf_pkg::REASON_BAD_IHL;
      end else if (header_end > frame_sum.length) begin
         verdict.verdict_reason = ipv4dbf_pkg::REASON_IHL_BEYOND;
      end else if (frame_sum.dest_address == blocked_address_ff) begin
         verdict.verdict_reason = ipv4dbf_pkg::REASON_DROP_MATCH;
      end else begin
         verdict.verdict_reason = ipv4dbf_pkg::REASON_OTHER_DEST;
      end
      verdict.drop_frame = (verdict.verdict_reason == ipv4dbf_pkg::REASON_DROP_MATCH);
   end

endmodule

[src/ipv4dbf_skid.sv]
module ipv4dbf_skid (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  ipv4dbf_pkg::verdict_type     in_verdict,
   output logic                         out_valid,
   input  logic                         out_ready,
   output ipv4dbf_pkg::verdict_type     out_verdict
);

   logic                     main_valid_ff, main_valid_in;
   logic                     skid_valid_ff, skid_valid_in;
   ipv4dbf_pkg::verdict_type main_ff, main_in;
   ipv4dbf_pkg::verdict_type skid_ff, skid_in;
   logic                     take;

   assign in_ready = ~skid_valid_ff;
   assign take     = main_valid_ff & out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_in       = in_verdict;
         end
      end else if (in_valid && !skid_valid_ff) begin
         if (main_valid_ff) begin
            skid_in       = in_verdict;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = in_verdict;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid   = main_valid_ff;
   assign out_verdict = main_ff;

endmodule

[src/ipv4_destination_block_filter_top.sv]
// Filters Ethernet frames on their IPv4 destination address. Frame bytes enter one per beat in
// wire order with req_tlast on the final byte; one byte is taken every cycle while the verdict
// buffer has room. Header fields are captured as the bytes pass, and the verdict for a frame is
// held in a two-entry output buffer in the cycle after its last byte; the input stalls only when
// two verdicts wait unread on the rsp side. Write the blocked address through
// csr_wr_en/csr_wr_data only while no frame is in flight.
module ipv4_destination_block_filter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] drop_frame, [3:1] verdict_reason, [7:4] zero
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data  // blocked_address
);

   ipv4dbf_pkg::frame_sum_type frame_sum;
   ipv4dbf_pkg::verdict_type   verdict;
   ipv4dbf_pkg::verdict_type   rsp_verdict;
   logic                       beat_accept;

   assign beat_accept = req_tvalid & req_tready;

   ipv4dbf_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .beat_accept (beat_accept),
      .frame_byte  (req_tdata),
      .last_byte   (req_tlast),
      .frame_sum   (frame_sum)
   );

   ipv4dbf_judge u_judge (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .frame_sum   (frame_sum),
      .verdict     (verdict)
   );

   ipv4dbf_skid u_skid (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (frame_sum.last),
      .in_ready    (req_tready),
      .in_verdict  (verdict),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_verdict (rsp_verdict)
   );

   assign rsp_tdata = {4'b0000, rsp_verdict.verdict_reason, rsp_verdict.drop_frame};

endmodule
